/* hw/rtl/qse_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qse_pkg
// Shared types and default constants for the sorting engine.
// ----------------------------------------------------------------------------
package qse_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    typedef enum logic {
        ST_LOAD  = 1'b0,
        ST_DRAIN = 1'b1
    } t_state;

    // per-cycle command broadcast to every cell of the row
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

endpackage

`default_nettype wire

/* hw/rtl/qse_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qse_cell
// One slot of the sorted row: keeps its value in order on insert and
// passes values toward the head of the row on drain.
// ----------------------------------------------------------------------------
module qse_cell #(
    parameter int VALUE_WIDTH = qse_pkg::VALUE_WIDTH_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire qse_pkg::t_cell_ctrl      i_ctrl,
    input  wire signed [VALUE_WIDTH-1:0]  i_new_value,
    input  wire signed [VALUE_WIDTH-1:0]  i_prev_value,
    input  wire                           i_prev_valid,
    input  wire                           i_prev_gt,
    input  wire signed [VALUE_WIDTH-1:0]  i_next_value,
    input  wire                           i_next_valid,
    output logic signed [VALUE_WIDTH-1:0] o_value,
    output logic                          o_valid,
    output logic                          o_gt
);

    logic signed [VALUE_WIDTH-1:0] r_value, n_value;
    logic                          r_valid, n_valid;

    assign o_gt    = r_valid && (r_value > i_new_value);
    assign o_value = r_value;
    assign o_valid = r_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.shift) begin
            n_value = i_next_value;
            n_valid = i_next_valid;
        end else if (i_ctrl.insert) begin
            if (o_gt || (!r_valid && i_prev_valid)) begin
                n_value = i_prev_gt ? i_prev_value : i_new_value;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/quicksort_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// quicksort_engine
// Sorts a set of signed values and returns them in ascending order.
// ----------------------------------------------------------------------------
// Values are taken one per cycle while o_busy is low; each one is placed in
// order as it arrives by a row of CAPACITY compare-and-shift cells, so the
// set is already sorted when the item marked last arrives. o_busy then rises
// and the row drains from its head, one result per cycle, the final one marked
// by o_last_out. Items beyond CAPACITY are dropped and every result of
// that set shows o_overflowed. Results are strobed by o_valid for one cycle
// and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module quicksort_engine #(
    parameter int CAPACITY    = qse_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = qse_pkg::VALUE_WIDTH_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    output logic                          o_busy,
    input  wire signed [VALUE_WIDTH-1:0]  i_value,
    input  wire                           i_last_in,
    output logic                          o_valid,
    output logic signed [VALUE_WIDTH-1:0] o_sorted_value,
    output logic                          o_last_out,
    output logic                          o_overflowed
);

    localparam int CW = $clog2(CAPACITY + 1);

    qse_pkg::t_state     r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic                r_ovf, n_ovf;
    qse_pkg::t_cell_ctrl ctrl;
    logic                accept;

    logic                          n_out_valid, n_out_last, n_out_ovf;
    logic signed [VALUE_WIDTH-1:0] n_out_value;

    logic signed [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic                          cell_valid [CAPACITY];
    logic                          cell_gt    [CAPACITY];

    assign o_busy = (r_state == qse_pkg::ST_DRAIN);
    assign accept = i_start && !o_busy;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [VALUE_WIDTH-1:0] prev_value, next_value;
            logic                          prev_valid, prev_gt, next_valid;
            if (g == 0) begin : g_head
                assign prev_value = i_value;
                assign prev_valid = 1'b1;
                assign prev_gt    = 1'b0;
            end else begin : g_body
                assign prev_value = cell_value[g-1];
                assign prev_valid = cell_valid[g-1];
                assign prev_gt    = cell_gt[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign next_value = i_value;
                assign next_valid = 1'b0;
            end else begin : g_inner
                assign next_value = cell_value[g+1];
                assign next_valid = cell_valid[g+1];
            end
            qse_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (ctrl),
                .i_new_value  (i_value),
                .i_prev_value (prev_value),
                .i_prev_valid (prev_valid),
                .i_prev_gt    (prev_gt),
                .i_next_value (next_value),
                .i_next_valid (next_valid),
                .o_value      (cell_value[g]),
                .o_valid      (cell_valid[g]),
                .o_gt         (cell_gt[g])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        ctrl.insert = 1'b0;
        ctrl.shift  = 1'b0;
        n_out_valid = 1'b0;
        n_out_value = cell_value[0];
        n_out_last  = 1'b0;
        n_out_ovf   = r_ovf;
        case (r_state)
            qse_pkg::ST_LOAD: begin
                if (accept) begin
                    if (r_count < CW'(CAPACITY)) begin
                        ctrl.insert = 1'b1;
                        n_count     = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_in) begin
                        n_state = qse_pkg::ST_DRAIN;
                    end
                end
            end
            qse_pkg::ST_DRAIN: begin
                ctrl.shift  = 1'b1;
                n_out_valid = 1'b1;
                n_count     = r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    n_out_last = 1'b1;
                    n_ovf      = 1'b0;
                    n_state    = qse_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = qse_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_sorted_value <= n_out_value;
        o_last_out     <= n_out_last;
        o_overflowed   <= n_out_ovf;
        if (!i_rst_n) begin
            r_state <= qse_pkg::ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            o_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for quicksort_engine. Sets of signed values are fed in
// with random gaps between transfers. An in-bench sorter builds the ascending
// sequence each set must produce, including the last and overflow marks. A
// monitor checks every strobed result against the oldest entry still owed.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CAPACITY       = qse_pkg::CAPACITY_DEF;
    localparam int VW             = qse_pkg::VALUE_WIDTH_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 200;

    typedef struct {
        logic signed [VW-1:0] value;
        logic                 last;
    } t_load_item;

    typedef struct {
        logic signed [VW-1:0] value;
        logic                 last;
        logic                 ovf;
    } t_sorted_entry;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 i_start   = 1'b0;
    logic signed [VW-1:0] i_value   = '0;
    logic                 i_last_in = 1'b0;
    logic                 o_busy;
    logic                 o_valid;
    logic signed [VW-1:0] o_sorted_value;
    logic                 o_last_out;
    logic                 o_overflowed;

    t_load_item           load_q[$];
    t_sorted_entry        owed_q[$];
    logic signed [VW-1:0] set_values[$];
    bit                   set_dropped;
    bit                   mismatch_seen;

    int                   hold_off;
    int                   quiet_run;
    int                   gap_roll;
    t_load_item           next_item;
    int                   idle_cycles;

    quicksort_engine #(
        .CAPACITY   (CAPACITY),
        .VALUE_WIDTH(VW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_value       (i_value),
        .i_last_in     (i_last_in),
        .o_valid       (o_valid),
        .o_sorted_value(o_sorted_value),
        .o_last_out    (o_last_out),
        .o_overflowed  (o_overflowed)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // store one accepted value; on the last one, sort the held set and owe it
    task automatic take_item(input logic signed [VW-1:0] v, input logic last);
        logic signed [VW-1:0] vals[$];
        logic signed [VW-1:0] key;
        t_sorted_entry        e;
        int                   j;
        if (set_values.size() < CAPACITY) begin
            set_values.push_back(v);
        end else begin
            set_dropped = 1'b1;
        end
        if (last) begin
            vals = set_values;
            for (int i = 1; i < vals.size(); i++) begin
                key = vals[i];
                j = i - 1;
                while (j >= 0 && vals[j] > key) begin
                    vals[j+1] = vals[j];
                    j--;
                end
                vals[j+1] = key;
            end
            for (int i = 0; i < vals.size(); i++) begin
                e.value = vals[i];
                e.last  = (i == vals.size() - 1);
                e.ovf   = set_dropped;
                owed_q.push_back(e);
            end
            set_values.delete();
            set_dropped = 1'b0;
        end
    endtask

    function automatic logic signed [VW-1:0] draw_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom;
        if (r < 9) return $signed($urandom_range(0, 14)) - 7;
        case ($urandom_range(0, 3))
            0: return {1'b1, {(VW-1){1'b0}}};
            1: return {1'b0, {(VW-1){1'b1}}};
            2: return '0;
            default: return '1;
        endcase
    endfunction

    task automatic add_set(input logic signed [VW-1:0] vals[$]);
        t_load_item it;
        foreach (vals[i]) begin
            it.value = vals[i];
            it.last  = (i == vals.size() - 1);
            load_q.push_back(it);
        end
    endtask

    task automatic add_random_set(input int len);
        logic signed [VW-1:0] vals[$];
        repeat (len) vals.push_back(draw_value());
        add_set(vals);
    endtask

    // driver: start held until the transfer completes, random gaps between items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) take_item(i_value, i_last_in);
            if (!i_start || !o_busy) begin
                if (hold_off > 0) begin
                    hold_off--;
                    i_start <= 1'b0;
                end else if (load_q.size() > 0) begin
                    next_item = load_q.pop_front();
                    i_start   <= 1'b1;
                    i_value   <= next_item.value;
                    i_last_in <= next_item.last;
                    if (quiet_run > 0) begin
                        quiet_run--;
                        hold_off = 0;
                    end else begin
                        gap_roll = $urandom_range(0, 99);
                        if (gap_roll < 4) quiet_run = $urandom_range(10, 40);
                        if (gap_roll < 50) hold_off = 0;
                        else if (gap_roll < 85) hold_off = $urandom_range(1, 3);
                        else if (gap_roll < 97) hold_off = $urandom_range(4, 10);
                        else hold_off = $urandom_range(20, 60);
                    end
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_sorted_entry e;
        if (i_rst_n && o_valid) begin
            if (owed_q.size() == 0) begin
                $error("unexpected result: sorted_value %0d", o_sorted_value);
                mismatch_seen = 1'b1;
            end else begin
                e = owed_q.pop_front();
                if (o_sorted_value !== e.value) begin
                    $error("sorted_value: expected %0d, got %0d", e.value, o_sorted_value);
                    mismatch_seen = 1'b1;
                end
                if (o_last_out !== e.last) begin
                    $error("last_out: expected %0b, got %0b", e.last, o_last_out);
                    mismatch_seen = 1'b1;
                end
                if (o_overflowed !== e.ovf) begin
                    $error("overflowed: expected %0b, got %0b", e.ovf, o_overflowed);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    // watchdog on cycles with no transfer in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int  total;
        bit  full_done;
        bit  over_done;
        logic signed [VW-1:0] vals[$];

        // extremes and alternating bit patterns
        add_set('{{1'b0, {(VW-1){1'b1}}}, {1'b1, {(VW-1){1'b0}}}, 0, -1, 1,
                  32'sh5555_5555, 32'shAAAA_AAAA});
        // single-element set
        add_set('{-5});
        // duplicates
        add_set('{3, 3, -3, 3, 3});
        // already ascending, then descending
        add_set('{-100, -2, 0, 7, 1000, 2000000000});
        add_set('{2000000000, 1000, 7, 0, -2, -100});

        // random part: small sets, one set at capacity, one that overflows
        total = 0;
        full_done = 0;
        over_done = 0;
        while (total < RANDOM_ITEMS || !full_done || !over_done) begin
            if (!full_done && (total > 60 || $urandom_range(0, 7) == 0)) begin
                add_random_set(CAPACITY);
                total += CAPACITY;
                full_done = 1;
            end else if (!over_done && (total > 120 || $urandom_range(0, 7) == 0)) begin
                // last_in lands on a dropped item
                vals.delete();
                repeat ($urandom_range(CAPACITY + 1, CAPACITY + 4)) vals.push_back(draw_value());
                add_set(vals);
                total += vals.size();
                over_done = 1;
            end else begin
                vals.delete();
                repeat ($urandom_range(1, 12)) vals.push_back(draw_value());
                add_set(vals);
                total += vals.size();
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (load_q.size() > 0 || i_start || owed_q.size() > 0) @(posedge i_clk);
        repeat (2 * CAPACITY + 16) @(posedge i_clk);

        if (!mismatch_seen) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/qse_pkg.sv
hw/rtl/qse_cell.sv
hw/rtl/quicksort_engine.sv
tb/testbench.sv
